[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dee_pkg.sv]
`default_nettype none
package dee_pkg;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [4:0] POW10_MAX_IDX = 5'd18;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_CHAR  = 3'd1,
    ERR_COUNT = 3'd2,
    ERR_FORM  = 3'd3,
    ERR_ARITH = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SRC_LEFT  = 2'd0,
    SRC_RIGHT = 2'd1,
    SRC_OPS   = 2'd2
  } src_t;

  typedef enum logic [2:0] {
    CAP_NONE   = 3'd0,
    CAP_A      = 3'd1,
    CAP_B      = 3'd2,
    CAP_ADDSUB = 3'd3,
    CAP_DIV    = 3'd4,
    CAP_DIVZ   = 3'd5,
    CAP_MUL    = 3'd6,
    CAP_ERR    = 3'd7
  } cap_t;

  typedef struct packed {
    logic take;
    logic div_start;
    src_t div_src;
    cap_t cap;
    logic mul_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    err_t err;
    op_t  op;
    logic b_zero;
    logic div_done;
    logic mul_done;
  } stat_t;

  function automatic logic [63:0] pow10(input logic [4:0] k);
    logic [63:0] p;
    case (k)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      default: p = 64'd1000000000000000000;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[rtl/core/dee_in_if.sv]
`default_nettype none
interface dee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface
`default_nettype wire

[rtl/core/dee_out_if.sv]
`default_nettype none
interface dee_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value_fixed;
  logic [2:0]         error_code;

  modport source (output valid, output value_fixed, output error_code, input ready);
  modport sink (input valid, input value_fixed, input error_code, output ready);
endinterface
`default_nettype wire

[rtl/core/dee_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle: floor(num * 2^FB / den),
// saturated to the largest positive value.
module dee_div #(
  parameter int FB = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [63:0] num,
  input  wire  [63:0] den,
  output logic [63:0] quo,
  output logic        ovf,
  output logic        done
);
  localparam int QW = 63 + FB;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [63:0]   rem_r, rem_nxt;
  logic [63:0]   den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [64:0]   rem_sh;
  logic [64:0]   rem_sub;
  logic          ge;

  assign rem_sh  = {rem_r, dvd_r[QW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {num[62:0], {FB{1'b0}}};
      quo_nxt  = '0;
      rem_nxt  = '0;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[QW-2:0], 1'b0};
      quo_nxt = {quo_r[QW-2:0], ge};
      rem_nxt = ge ? rem_sub[63:0] : rem_sh[63:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      den_r <= den;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign ovf  = |quo_r[QW-1:63];
  assign quo  = ovf ? dee_pkg::SMAX : {1'b0, quo_r[62:0]};
  assign done = done_r;
endmodule
`default_nettype wire

[rtl/core/dee_dp.sv]
`default_nettype none
// Datapath: character parser, operand conversion, multiplier and result registers.
module dee_dp #(
  parameter int FRACTION_BITS       = 16,
  parameter int MAX_FRACTION_DIGITS = 18
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [7:0]          char_code,
  input  dee_pkg::cmd_t       cmd,
  output dee_pkg::stat_t      stat,
  output logic signed [63:0]  value_fixed,
  output logic [2:0]          error_code
);
  typedef enum logic [5:0] {
    PH_LINT  = 6'b000001,
    PH_LFRAC = 6'b000010,
    PH_OP    = 6'b000100,
    PH_SP2   = 6'b001000,
    PH_RINT  = 6'b010000,
    PH_RFRAC = 6'b100000
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [63:0]    ml_r, ml_nxt, mr_r, mr_nxt;
  logic [4:0]     kl_r, kl_nxt, kr_r, kr_nxt;
  dee_pkg::op_t   opk_r, opk_nxt;
  logic [1:0]     opc_r, opc_nxt, spc_r, spc_nxt, ptc_r, ptc_nxt;
  logic           bad_r, bad_nxt, malf_r, malf_nxt, ovf_r, ovf_nxt;

  logic           is_digit, is_op, is_pt, is_sp, is_left, in_num, is_frac;
  dee_pkg::op_t   op_dec;
  logic [3:0]     dgt;
  logic [63:0]    m_sel;
  logic [4:0]     k_sel;
  logic [67:0]    m_x10;
  logic           fits, frac_full;
  logic [63:0]    m_new;
  logic [4:0]     k_new;
  logic           dig_ovf;

  logic [63:0]    a_r, b_r, res_r;
  dee_pkg::err_t  code_r, code_nxt_ld;
  logic [63:0]    vout_r;
  dee_pkg::err_t  cout_r;

  logic [63:0]    div_num, div_den, div_quo;
  logic           div_ovf;
  logic [4:0]     k_clamp;

  logic [63:0]    sum;
  logic [127:0]   acc_r;
  logic [63:0]    pp_r;
  logic [1:0]     psh_r;
  logic [2:0]     mcnt_r;
  logic           mbusy_r;
  logic [31:0]    mul_x, mul_y;
  logic [127:0]   acc_sh;
  logic           mul_ovf;
  logic [127:0]   acc_add;
  dee_pkg::err_t  err;

  // Character decode.
  always_comb begin
    is_digit = (char_code >= dee_pkg::CH_ZERO) && (char_code <= dee_pkg::CH_NINE);
    is_pt    = char_code == dee_pkg::CH_POINT;
    is_sp    = char_code == dee_pkg::CH_SPACE;
    is_op    = 1'b1;
    case (char_code)
      dee_pkg::CH_PLUS:  op_dec = dee_pkg::OP_ADD;
      dee_pkg::CH_MINUS: op_dec = dee_pkg::OP_SUB;
      dee_pkg::CH_STAR:  op_dec = dee_pkg::OP_MUL;
      dee_pkg::CH_SLASH: op_dec = dee_pkg::OP_DIV;
      default: begin
        op_dec = dee_pkg::OP_ADD;
        is_op  = 1'b0;
      end
    endcase
    dgt     = char_code[3:0];
    is_left = (phase_r == PH_LINT) || (phase_r == PH_LFRAC);
    is_frac = (phase_r == PH_LFRAC) || (phase_r == PH_RFRAC);
    in_num  = is_left || (phase_r == PH_RINT) || (phase_r == PH_RFRAC);
  end

  // One decimal digit into the selected mantissa.
  always_comb begin
    m_sel     = is_left ? ml_r : mr_r;
    k_sel     = is_left ? kl_r : kr_r;
    m_x10     = {1'b0, m_sel, 3'b000} + {3'b000, m_sel, 1'b0} + {64'd0, dgt};
    fits      = m_x10 <= {4'd0, dee_pkg::SMAX};
    frac_full = is_frac && (k_sel >= 5'(MAX_FRACTION_DIGITS));
    m_new     = m_sel;
    k_new     = k_sel;
    dig_ovf   = 1'b0;
    if (!frac_full) begin
      if (!fits) begin
        if (!is_frac) begin
          dig_ovf = 1'b1;
          m_new   = dee_pkg::SMAX;
        end
      end else begin
        m_new = m_x10[63:0];
        if (is_frac) begin
          k_new = k_sel + 5'd1;
        end
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    ml_nxt    = ml_r;
    mr_nxt    = mr_r;
    kl_nxt    = kl_r;
    kr_nxt    = kr_r;
    opk_nxt   = opk_r;
    opc_nxt   = opc_r;
    spc_nxt   = spc_r;
    ptc_nxt   = ptc_r;
    bad_nxt   = bad_r;
    malf_nxt  = malf_r;
    ovf_nxt   = ovf_r;
    if (cmd.take) begin
      if (!is_digit && !is_op && !is_pt && !is_sp) begin
        bad_nxt = 1'b1;
      end else begin
        if (is_op && opc_r != 2'd3) begin
          opc_nxt = opc_r + 2'd1;
        end
        if (is_sp && spc_r != 2'd3) begin
          spc_nxt = spc_r + 2'd1;
        end
        if (is_pt && ptc_r != 2'd3) begin
          ptc_nxt = ptc_r + 2'd1;
        end
        if (!malf_r) begin
          if (is_digit && in_num) begin
            if (is_left) begin
              ml_nxt = m_new;
              kl_nxt = k_new;
            end else begin
              mr_nxt = m_new;
              kr_nxt = k_new;
            end
            ovf_nxt = ovf_r | dig_ovf;
          end else if (is_pt && phase_r == PH_LINT) begin
            phase_nxt = PH_LFRAC;
          end else if (is_pt && phase_r == PH_RINT) begin
            phase_nxt = PH_RFRAC;
          end else if (is_sp && is_left) begin
            phase_nxt = PH_OP;
          end else if (is_op && phase_r == PH_OP) begin
            opk_nxt   = op_dec;
            phase_nxt = PH_SP2;
          end else if (is_sp && phase_r == PH_SP2) begin
            phase_nxt = PH_RINT;
          end else begin
            malf_nxt = 1'b1;
          end
        end
      end
    end
    // Arithmetic overflow folds into the same flag.
    case (cmd.cap)
      dee_pkg::CAP_A, dee_pkg::CAP_B, dee_pkg::CAP_DIV: ovf_nxt = ovf_nxt | div_ovf;
      dee_pkg::CAP_ADDSUB: ovf_nxt = ovf_nxt | ((opk_r == dee_pkg::OP_ADD) && sum[63]);
      dee_pkg::CAP_DIVZ:   ovf_nxt = 1'b1;
      dee_pkg::CAP_MUL:    ovf_nxt = ovf_nxt | mul_ovf;
      default: ovf_nxt = ovf_nxt;
    endcase
  end

  // Error ranking on the finished text.
  always_comb begin
    if (bad_r) begin
      err = dee_pkg::ERR_CHAR;
    end else if (opc_r != 2'd1 || spc_r != 2'd2 || ptc_r == 2'd3) begin
      err = dee_pkg::ERR_COUNT;
    end else if (malf_r || (phase_r != PH_RINT && phase_r != PH_RFRAC)) begin
      err = dee_pkg::ERR_FORM;
    end else begin
      err = dee_pkg::ERR_OK;
    end
  end

  // Divider operand select.
  always_comb begin
    case (cmd.div_src)
      dee_pkg::SRC_LEFT: begin
        div_num = ml_r;
        k_clamp = (kl_r > dee_pkg::POW10_MAX_IDX) ? dee_pkg::POW10_MAX_IDX : kl_r;
        div_den = dee_pkg::pow10(k_clamp);
      end
      dee_pkg::SRC_RIGHT: begin
        div_num = mr_r;
        k_clamp = (kr_r > dee_pkg::POW10_MAX_IDX) ? dee_pkg::POW10_MAX_IDX : kr_r;
        div_den = dee_pkg::pow10(k_clamp);
      end
      default: begin
        div_num = a_r;
        k_clamp = '0;
        div_den = b_r;
      end
    endcase
  end

  dee_div #(
    .FB(FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .ovf   (div_ovf),
    .done  (stat.div_done)
  );

  assign sum = (opk_r == dee_pkg::OP_ADD) ? (a_r + b_r) : (a_r - b_r);

  // Four 32x32 partial products, one a cycle, each registered in pp_r before it is added into acc_r.
  assign mul_x   = mcnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign mul_y   = mcnt_r[0] ? b_r[63:32] : b_r[31:0];
  assign acc_add = acc_r + ({64'd0, pp_r} << {psh_r, 5'd0});
  assign acc_sh  = acc_r >> FRACTION_BITS;
  assign mul_ovf = |(acc_r >> (63 + FRACTION_BITS));

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      acc_r <= '0;
    end else if (mbusy_r && mcnt_r != 3'd0) begin
      acc_r <= acc_add;
    end
    if (mbusy_r && mcnt_r != 3'd4) begin
      pp_r  <= 64'(mul_x * mul_y);
      psh_r <= 2'(mcnt_r[1]) + 2'(mcnt_r[0]);
    end
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mcnt_r  <= '0;
    end else if (cmd.mul_start) begin
      mbusy_r <= 1'b1;
      mcnt_r  <= '0;
    end else if (mbusy_r) begin
      mcnt_r <= mcnt_r + 3'd1;
      if (mcnt_r == 3'd4) begin
        mbusy_r <= 1'b0;
      end
    end
  end

  assign stat.mul_done = mbusy_r && (mcnt_r == 3'd4);
  assign stat.err      = err;
  assign stat.op       = opk_r;
  assign stat.b_zero   = b_r == 64'd0;

  always_comb begin
    if (code_r != dee_pkg::ERR_OK) begin
      code_nxt_ld = code_r;
    end else if (ovf_r) begin
      code_nxt_ld = dee_pkg::ERR_ARITH;
    end else begin
      code_nxt_ld = dee_pkg::ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.cap)
      dee_pkg::CAP_A:      a_r <= div_quo;
      dee_pkg::CAP_B:      b_r <= div_quo;
      dee_pkg::CAP_ADDSUB: res_r <= ((opk_r == dee_pkg::OP_ADD) && sum[63]) ? dee_pkg::SMAX : sum;
      dee_pkg::CAP_DIV:    res_r <= div_quo;
      dee_pkg::CAP_DIVZ:   res_r <= '0;
      dee_pkg::CAP_MUL:    res_r <= mul_ovf ? dee_pkg::SMAX : acc_sh[63:0];
      dee_pkg::CAP_ERR:    res_r <= '0;
      default:             res_r <= res_r;
    endcase
    if (cmd.load_out) begin
      vout_r <= res_r;
      cout_r <= code_nxt_ld;
    end
    if (!rst_n || cmd.load_out) begin
      phase_r <= PH_LINT;
      ml_r    <= '0;
      mr_r    <= '0;
      kl_r    <= '0;
      kr_r    <= '0;
      opk_r   <= dee_pkg::OP_ADD;
      opc_r   <= '0;
      spc_r   <= '0;
      ptc_r   <= '0;
      bad_r   <= 1'b0;
      malf_r  <= 1'b0;
      ovf_r   <= 1'b0;
      code_r  <= dee_pkg::ERR_OK;
    end else begin
      phase_r <= phase_nxt;
      ml_r    <= ml_nxt;
      mr_r    <= mr_nxt;
      kl_r    <= kl_nxt;
      kr_r    <= kr_nxt;
      opk_r   <= opk_nxt;
      opc_r   <= opc_nxt;
      spc_r   <= spc_nxt;
      ptc_r   <= ptc_nxt;
      bad_r   <= bad_nxt;
      malf_r  <= malf_nxt;
      ovf_r   <= ovf_nxt;
      if (cmd.cap == dee_pkg::CAP_ERR) begin
        code_r <= err;
      end
    end
  end

  assign value_fixed = vout_r;
  assign error_code  = cout_r;
endmodule
`default_nettype wire

[rtl/core/dee_ctrl.sv]
`default_nettype none
// Sequencer: takes characters, then walks the datapath through evaluation.
module dee_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  input  wire             in_end_of_text,
  output logic            in_ready,
  output logic            out_valid,
  input  wire             out_ready,
  input  dee_pkg::stat_t  stat,
  output dee_pkg::cmd_t   cmd
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_CONVA  = 9'b000000100,
    S_CONVB  = 9'b000001000,
    S_ARITH  = 9'b000010000,
    S_MUL    = 9'b000100000,
    S_MULCAP = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovld_r, ovld_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt     = state_r;
    ovld_nxt      = ovld_r && !out_ready;
    cmd           = '0;
    cmd.div_src   = dee_pkg::SRC_LEFT;
    cmd.cap       = dee_pkg::CAP_NONE;
    case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && in_end_of_text) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.err != dee_pkg::ERR_OK) begin
          cmd.cap   = dee_pkg::CAP_ERR;
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_CONVA;
        end
      end
      S_CONVA: begin
        if (stat.div_done) begin
          cmd.cap       = dee_pkg::CAP_A;
          cmd.div_start = 1'b1;
          cmd.div_src   = dee_pkg::SRC_RIGHT;
          state_nxt     = S_CONVB;
        end
      end
      S_CONVB: begin
        cmd.div_src = dee_pkg::SRC_RIGHT;
        if (stat.div_done) begin
          cmd.cap   = dee_pkg::CAP_B;
          state_nxt = S_ARITH;
        end
      end
      S_ARITH: begin
        case (stat.op)
          dee_pkg::OP_MUL: begin
            cmd.mul_start = 1'b1;
            state_nxt     = S_MUL;
          end
          dee_pkg::OP_DIV: begin
            if (stat.b_zero) begin
              cmd.cap   = dee_pkg::CAP_DIVZ;
              state_nxt = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_src   = dee_pkg::SRC_OPS;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            cmd.cap   = dee_pkg::CAP_ADDSUB;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MUL: begin
        if (stat.mul_done) begin
          state_nxt = S_MULCAP;
        end
      end
      S_MULCAP: begin
        cmd.cap   = dee_pkg::CAP_MUL;
        state_nxt = S_DONE;
      end
      S_DIV: begin
        cmd.div_src = dee_pkg::SRC_OPS;
        if (stat.div_done) begin
          cmd.cap   = dee_pkg::CAP_DIV;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovld_r || out_ready) begin
          cmd.load_out = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/core/decimal_expression_evaluator.sv]
// Evaluates a text expression "number space operator space number" that arrives one
// ASCII character per transfer, the last character flagged by end_of_text, and returns
// one result per expression: a signed fixed-point value with FRACTION_BITS fraction bits
// (truncated) and an error code (0 ok, 1 bad character, 2 bad counts, 3 malformed, 4
// divide by zero or overflow, with the value saturated or zero). Characters are taken at
// one per cycle while the block is idle. After the last character the block ranks errors
// and, if it finds none, converts each operand with a bit-serial divider and applies the
// operator; the divider serves both conversions and the divide operator. While it works
// the input is not ready; a finished result waits in the output register and the next
// expression's characters are taken meanwhile.
`default_nettype none
`include "assert_macros.svh"
module decimal_expression_evaluator #(
  parameter int FRACTION_BITS       = 16,
  parameter int MAX_FRACTION_DIGITS = 18
) (
  input  wire clk,
  input  wire rst_n,
  dee_in_if.sink    in_chan,
  dee_out_if.source out_chan
);

  // Command and status between the sequencer and the datapath.
  dee_pkg::cmd_t  cmd;
  dee_pkg::stat_t stat;

  // The sequencer owns both handshakes; the datapath sees only commands and the character code.
  dee_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_end_of_text (in_chan.end_of_text),
    .in_ready       (in_chan.ready),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .stat           (stat),
    .cmd            (cmd)
  );

  // Parser, conversion divider, multiplier and output register live here.
  dee_dp #(
    .FRACTION_BITS       (FRACTION_BITS),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_code   (in_chan.char_code),
    .cmd         (cmd),
    .stat        (stat),
    .value_fixed (out_chan.value_fixed),
    .error_code  (out_chan.error_code)
  );

  // No character may be taken while the divider is busy finishing a result.
  `ASSERT_SAME(a_no_take_in_div, clk, rst_n, stat.div_done, !cmd.take, "take during divide")
  // An error result is only captured when the ranking found an error.
  `ASSERT_SAME(a_err_cap, clk, rst_n, cmd.cap == dee_pkg::CAP_ERR,
               stat.err != dee_pkg::ERR_OK, "error capture without error")
  // Loading the output register always presents a result next cycle.
  `ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load_out, out_chan.valid, "load without valid")

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
`default_nettype none

// Self-checking bench for the decimal expression evaluator.
// Characters of "number space operator space number" expressions are streamed
// into the block, a behavioral copy of the parser and fixed-point arithmetic
// predicts each result, and every result transfer is compared field by field.
module tb;

  localparam int FRAC_BITS = 16;
  localparam int MAX_FRAC_DIGITS = 18;
  localparam int CYCLE_LIMIT = 600000;

  // Parser stages of one expression.
  localparam logic [2:0] STG_LEFT_INT  = 3'd0;
  localparam logic [2:0] STG_LEFT_FRAC = 3'd1;
  localparam logic [2:0] STG_OPERATOR  = 3'd2;
  localparam logic [2:0] STG_SPACE_TWO = 3'd3;
  localparam logic [2:0] STG_RIGHT_INT = 3'd4;
  localparam logic [2:0] STG_RIGHT_FRAC = 3'd5;

  typedef struct {
    bit [7:0] code;
    bit       last;
  } char_item_t;

  typedef struct {
    logic [63:0]   value;
    dee_pkg::err_t code;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dee_in_if  in_chan ();
  dee_out_if out_chan ();

  decimal_expression_evaluator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Characters waiting to be offered, and answers waiting to come back.
  char_item_t char_queue[$];
  answer_t    answer_queue[$];
  bit [7:0]   text_buf[$];

  int mismatches = 0;
  int results_seen = 0;
  int chars_sent = 0;
  int code_hits[5];
  int cycle_count = 0;

  // Predictor state: one expression in flight.
  logic [2:0]   stage;
  logic [63:0]  lhs_mant, rhs_mant;
  logic [4:0]   lhs_digits, rhs_digits;
  dee_pkg::op_t op_sel;
  logic [1:0]   n_ops, n_spaces, n_points;
  bit           saw_bad, saw_form, saw_ovf;
  bit           calc_ovf;

  task automatic clear_expression();
    stage = STG_LEFT_INT;
    lhs_mant = '0;
    rhs_mant = '0;
    lhs_digits = '0;
    rhs_digits = '0;
    op_sel = dee_pkg::OP_ADD;
    n_ops = '0;
    n_spaces = '0;
    n_points = '0;
    saw_bad = 1'b0;
    saw_form = 1'b0;
    saw_ovf = 1'b0;
  endtask

  function automatic logic [1:0] bump(input logic [1:0] c);
    return (c == 2'd3) ? c : c + 2'd1;
  endfunction

  // Appends one decimal digit to a mantissa. Fraction digits that do not fit
  // are dropped; an integer digit that does not fit saturates and flags overflow.
  task automatic append_digit(inout logic [63:0] mant, inout logic [4:0] digits,
                              input int d, input bit frac);
    if (frac && digits >= MAX_FRAC_DIGITS) return;
    if (mant > (dee_pkg::SMAX - d) / 10) begin
      if (!frac) begin
        saw_ovf = 1'b1;
        mant = dee_pkg::SMAX;
      end
      return;
    end
    mant = mant * 10 + d;
    if (frac) digits = digits + 5'd1;
  endtask

  // floor(m * 2^FRAC_BITS / 10^k), saturated when the integer part is too big.
  function automatic logic [63:0] scale_operand(input logic [63:0] m, input logic [4:0] k);
    logic [127:0] p;
    logic [127:0] wide;
    int idx;
    p = 1;
    idx = (k > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : k;
    for (int i = 0; i < idx; i++) p = p * 10;
    if ((m / p) > (dee_pkg::SMAX >> FRAC_BITS)) begin
      calc_ovf = 1'b1;
      return dee_pkg::SMAX;
    end
    wide = ({64'd0, m} << FRAC_BITS) / p;
    return wide[63:0];
  endfunction

  function automatic answer_t evaluate();
    answer_t r;
    logic [63:0] a, b;
    logic [127:0] wide;
    r.value = '0;
    if (saw_bad) r.code = dee_pkg::ERR_CHAR;
    else if (n_ops != 2'd1 || n_spaces != 2'd2 || n_points > 2'd2) r.code = dee_pkg::ERR_COUNT;
    else if (saw_form || stage < STG_RIGHT_INT || stage > STG_RIGHT_FRAC)
      r.code = dee_pkg::ERR_FORM;
    else begin
      calc_ovf = saw_ovf;
      a = scale_operand(lhs_mant, lhs_digits);
      b = scale_operand(rhs_mant, rhs_digits);
      case (op_sel)
        dee_pkg::OP_ADD: begin
          r.value = a + b;
          if (r.value > dee_pkg::SMAX) begin
            r.value = dee_pkg::SMAX;
            calc_ovf = 1'b1;
          end
        end
        dee_pkg::OP_SUB: r.value = a - b;
        dee_pkg::OP_MUL: begin
          wide = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
          if (wide > dee_pkg::SMAX) begin
            r.value = dee_pkg::SMAX;
            calc_ovf = 1'b1;
          end else r.value = wide[63:0];
        end
        default: begin
          if (b == 0) begin
            r.value = '0;
            calc_ovf = 1'b1;
          end else begin
            wide = ({64'd0, a} << FRAC_BITS) / b;
            if (wide > dee_pkg::SMAX) begin
              r.value = dee_pkg::SMAX;
              calc_ovf = 1'b1;
            end else r.value = wide[63:0];
          end
        end
      endcase
      r.code = calc_ovf ? dee_pkg::ERR_ARITH : dee_pkg::ERR_OK;
    end
    return r;
  endfunction

  // Advances the predictor by one accepted character.
  task automatic parse_char(input char_item_t it);
    bit is_digit;
    bit is_op;
    dee_pkg::op_t op_code;
    bit frac;
    is_digit = it.code >= dee_pkg::CH_ZERO && it.code <= dee_pkg::CH_NINE;
    is_op = 1'b1;
    op_code = dee_pkg::OP_ADD;
    case (it.code)
      dee_pkg::CH_PLUS:  op_code = dee_pkg::OP_ADD;
      dee_pkg::CH_MINUS: op_code = dee_pkg::OP_SUB;
      dee_pkg::CH_STAR:  op_code = dee_pkg::OP_MUL;
      dee_pkg::CH_SLASH: op_code = dee_pkg::OP_DIV;
      default:           is_op = 1'b0;
    endcase
    if (!is_digit && !is_op && it.code != dee_pkg::CH_POINT
        && it.code != dee_pkg::CH_SPACE) begin
      saw_bad = 1'b1;
    end else begin
      if (is_op) n_ops = bump(n_ops);
      else if (it.code == dee_pkg::CH_SPACE) n_spaces = bump(n_spaces);
      else if (it.code == dee_pkg::CH_POINT) n_points = bump(n_points);
      if (!saw_form) begin
        if (is_digit && (stage <= STG_LEFT_FRAC || stage >= STG_RIGHT_INT)) begin
          frac = (stage == STG_LEFT_FRAC || stage == STG_RIGHT_FRAC);
          if (stage <= STG_LEFT_FRAC)
            append_digit(lhs_mant, lhs_digits, int'(it.code - dee_pkg::CH_ZERO), frac);
          else
            append_digit(rhs_mant, rhs_digits, int'(it.code - dee_pkg::CH_ZERO), frac);
        end else if (it.code == dee_pkg::CH_POINT
                     && (stage == STG_LEFT_INT || stage == STG_RIGHT_INT)) begin
          stage = stage + 3'd1;
        end else if (it.code == dee_pkg::CH_SPACE && stage <= STG_LEFT_FRAC) begin
          stage = STG_OPERATOR;
        end else if (is_op && stage == STG_OPERATOR) begin
          op_sel = op_code;
          stage = STG_SPACE_TWO;
        end else if (it.code == dee_pkg::CH_SPACE && stage == STG_SPACE_TWO) begin
          stage = STG_RIGHT_INT;
        end else begin
          saw_form = 1'b1;
        end
      end
    end
    if (it.last) begin
      answer_queue.push_back(evaluate());
      clear_expression();
    end
  endtask

  // Stimulus building: text_buf collects one expression, then it is queued
  // with the end flag on its final character.
  task automatic flush_text();
    char_item_t it;
    for (int i = 0; i < text_buf.size(); i++) begin
      it.code = text_buf[i];
      it.last = (i == text_buf.size() - 1);
      char_queue.push_back(it);
    end
    text_buf.delete();
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    flush_text();
  endtask

  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++)
      text_buf.push_back(8'(dee_pkg::CH_ZERO + $urandom_range(0, 9)));
  endtask

  // Most numbers are short; a few run long enough to hit saturation and the
  // fraction digit cap.
  task automatic add_number();
    bit long_one;
    long_one = ($urandom_range(0, 9) == 0);
    add_digits(long_one ? $urandom_range(10, 21) : $urandom_range(0, 6));
    if ($urandom_range(0, 1)) begin
      text_buf.push_back(dee_pkg::CH_POINT);
      add_digits(long_one ? $urandom_range(10, 22) : $urandom_range(0, 6));
    end
  endtask

  task automatic add_expression();
    bit [7:0] ops[4];
    int pick;
    ops = '{dee_pkg::CH_PLUS, dee_pkg::CH_MINUS, dee_pkg::CH_STAR, dee_pkg::CH_SLASH};
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Pure noise, any byte value.
      repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_number();
      text_buf.push_back(dee_pkg::CH_SPACE);
      text_buf.push_back(ops[$urandom_range(0, 3)]);
      text_buf.push_back(dee_pkg::CH_SPACE);
      add_number();
      if (pick < 27) begin
        // Break a well-formed expression: overwrite, drop or add one character.
        case ($urandom_range(0, 2))
          0: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
          1: text_buf.delete($urandom_range(0, text_buf.size() - 1));
          default: text_buf.insert($urandom_range(0, text_buf.size()),
                                   ($urandom_range(0, 1)) ? dee_pkg::CH_POINT
                                                          : ops[$urandom_range(0, 3)]);
        endcase
        if (text_buf.size() == 0) text_buf.push_back(dee_pkg::CH_SPACE);
      end
    end
    flush_text();
  endtask

  // Driver: offers the head of char_queue and holds it until it is taken.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.char_code <= '0;
      in_chan.end_of_text <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        parse_char(char_queue.pop_front());
        chars_sent++;
      end
      if (!(in_chan.valid && !in_chan.ready)) begin
        if (send_gap > 0) begin
          in_chan.valid <= 1'b0;
          send_gap--;
        end else if (char_queue.size() > 150 && $urandom_range(0, 11) == 0) begin
          in_chan.valid <= 1'b0;
          send_gap = $urandom_range(0, 8);
        end else if (char_queue.size() > 0) begin
          in_chan.valid <= 1'b1;
          in_chan.char_code <= char_queue[0].code;
          in_chan.end_of_text <= char_queue[0].last;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, so that a finished result sits in the output
  // register while the next expression fills the block and stalls the input.
  int hold_left = 0;
  bit hold_used = 1'b0;
  always @(posedge clk) begin
    if (!hold_used && results_seen >= 30) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: toggles ready in bursts and checks every result transfer.
  int recv_gap = 0;
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (answer_queue.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected result: value %0d code %0d", $signed(out_chan.value_fixed),
                     out_chan.error_code);
          mismatches++;
        end else begin
          want = answer_queue.pop_front();
          if (out_chan.value_fixed !== want.value || out_chan.error_code !== want.code) begin
            if (mismatches < 10)
              $display("Mismatch on result %0d: expected value %0d code %0d, %s %0d code %0d",
                       results_seen, $signed(want.value), want.code, "got value",
                       $signed(out_chan.value_fixed), out_chan.error_code);
            mismatches++;
          end
          if (want.code <= dee_pkg::ERR_ARITH) code_hits[want.code]++;
        end
        results_seen++;
      end
      if (hold_left > 0 || recv_gap > 0) begin
        out_chan.ready <= 1'b0;
        if (recv_gap > 0) recv_gap--;
      end else if (char_queue.size() > 150 && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        recv_gap = $urandom_range(0, 8);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    clear_expression();

    // Directed expressions: every operator, extremes, and each error kind.
    push_string("0 + 0");
    push_string("1.5 * 2.25");
    push_string("3 - 5.75");
    push_string("7 / 2");
    push_string("1 / 0");
    push_string("9223372036854775808 + 1");
    push_string("140737488355327 + 1");
    push_string("140737488355328 - 1");
    push_string("99999999 * 99999999");
    push_string("9999999999 / .00001");
    push_string(".1234567890123456789012 + 0.99999999999999999999");
    push_string(". + .");
    push_string("12a + 3");
    push_string("\377");
    push_string("1 + 2 + 3");
    push_string("1 +");
    push_string("+ 1 2");
    push_string("1.2.3 + 4");
    push_string("5 * 6 7");
    push_string("1  +");
    push_string("12.5 /");

    while (char_queue.size() < 1200) add_expression();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (char_queue.size() > 0 || answer_queue.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d characters and checked %0d results.", chars_sent, results_seen);
    $display("Codes seen: ok %0d, bad char %0d, bad counts %0d, malformed %0d, arith %0d",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4]);
    if (mismatches == 0 && answer_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
